// ===== rtl/pcross_pkg.sv =====
// shared codes for the polyline segment crossing check
// request kinds and orientation codes; no dependencies
package pcross_pkg;

    // request kinds carried in the low tuser bits
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_VERTEX = 2'd1;
    localparam logic [1:0] OP_REPORT = 2'd2;

    localparam int OP_BITS = 2;

    // orientation of an ordered point triple
    localparam logic [1:0] ORIENT_COLLINEAR = 2'd0;
    localparam logic [1:0] ORIENT_POS       = 2'd1;
    localparam logic [1:0] ORIENT_NEG       = 2'd2;

    localparam int ORIENT_BITS = 2;

endpackage

// ===== rtl/polyline_segment_crossing_check.sv =====
// Accepts one request per clock on the slave stream and registers it; the next cycle a single
// evaluation stage (four cross products with two multipliers each, run side by side) tests the
// segment from the previous vertex to this vertex against the stored query segment and ORs a
// hit into the crossing flag. Every request kind passes through that stage, so the sustained
// rate is one request per cycle unless a report stalls; a report request puts its crossing
// result into the output register, so the result reaches the master stream through the input
// register and then the output register. The input side stalls only when a report reaches the
// evaluation stage while the previous result is still waiting in the output register.
// Depends on pcross_pkg, pcross_seg_test and pcross_orient.
module polyline_segment_crossing_check #(
    parameter int COORD_BITS = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // ax, ay, bx, by_coord from bit 0 up, zero filled to whole bytes
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]           s_tdata,
    // op, new_polyline from bit 0 up
    input  logic [pcross_pkg::OP_BITS:0]                s_tuser,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // crossing at bit 0, upper bits zero
    output logic [7:0]                                  m_tdata
);
    import pcross_pkg::*;

    localparam int CB = COORD_BITS;

    // input register
    logic                  in_valid_reg,  in_valid_next;
    logic [OP_BITS-1:0]    in_op_reg;
    logic                  in_new_reg;
    logic signed [CB-1:0]  in_ax_reg;
    logic signed [CB-1:0]  in_ay_reg;
    logic signed [CB-1:0]  in_bx_reg;
    logic signed [CB-1:0]  in_by_reg;

    // block state
    logic signed [CB-1:0]  q_ax_reg, q_ax_next;
    logic signed [CB-1:0]  q_ay_reg, q_ay_next;
    logic signed [CB-1:0]  q_bx_reg, q_bx_next;
    logic signed [CB-1:0]  q_by_reg, q_by_next;
    logic signed [CB-1:0]  prev_x_reg, prev_x_next;
    logic signed [CB-1:0]  prev_y_reg, prev_y_next;
    logic                  have_prev_reg, have_prev_next;
    logic                  hit_reg, hit_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic                  out_cross_reg, out_cross_next;

    logic                  advance;
    logic                  seg_meet;

    assign advance  = in_valid_reg &&
                      ((in_op_reg != OP_REPORT) || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_cross_reg};

    pcross_seg_test #(.COORD_BITS(CB)) u_seg (
        .p1x (q_ax_reg),
        .p1y (q_ay_reg),
        .q1x (q_bx_reg),
        .q1y (q_by_reg),
        .p2x (prev_x_reg),
        .p2y (prev_y_reg),
        .q2x (in_ax_reg),
        .q2y (in_ay_reg),
        .meet(seg_meet)
    );

    always_comb
    begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        q_ax_next      = q_ax_reg;
        q_ay_next      = q_ay_reg;
        q_bx_next      = q_bx_reg;
        q_by_next      = q_by_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        have_prev_next = have_prev_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_cross_next = out_cross_reg;
        if (advance)
        begin
            case (in_op_reg)
                OP_LOAD:
                begin
                    q_ax_next      = in_ax_reg;
                    q_ay_next      = in_ay_reg;
                    q_bx_next      = in_bx_reg;
                    q_by_next      = in_by_reg;
                    hit_next       = 1'b0;
                    have_prev_next = 1'b0;
                end
                OP_VERTEX:
                begin
                    // first vertex of a polyline is only stored
                    if (!in_new_reg && have_prev_reg && seg_meet)
                        hit_next = 1'b1;
                    prev_x_next    = in_ax_reg;
                    prev_y_next    = in_ay_reg;
                    have_prev_next = 1'b1;
                end
                OP_REPORT:
                begin
                    out_valid_next = 1'b1;
                    out_cross_next = hit_reg;
                    have_prev_next = 1'b0;
                end
                default:
                begin
                    // unused kind is dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            q_ax_reg      <= '0;
            q_ay_reg      <= '0;
            q_bx_reg      <= '0;
            q_by_reg      <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            q_ax_reg      <= q_ax_next;
            q_ay_reg      <= q_ay_next;
            q_bx_reg      <= q_bx_next;
            q_by_reg      <= q_by_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            have_prev_reg <= have_prev_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_cross_reg <= out_cross_next;
        if (s_tready && s_tvalid)
        begin
            in_op_reg  <= s_tuser[OP_BITS-1:0];
            in_new_reg <= s_tuser[OP_BITS];
            in_ax_reg  <= s_tdata[CB-1:0];
            in_ay_reg  <= s_tdata[2*CB-1:CB];
            in_bx_reg  <= s_tdata[3*CB-1:2*CB];
            in_by_reg  <= s_tdata[4*CB-1:3*CB];
        end
    end

endmodule

// ===== rtl/pcross_orient.sv =====
// orientation of three points from the sign of one cross product
// uses pcross_pkg for the orientation codes
module pcross_orient #(
    parameter int COORD_BITS = 16
) (
    input  logic signed [COORD_BITS-1:0]         px,
    input  logic signed [COORD_BITS-1:0]         py,
    input  logic signed [COORD_BITS-1:0]         qx,
    input  logic signed [COORD_BITS-1:0]         qy,
    input  logic signed [COORD_BITS-1:0]         rx,
    input  logic signed [COORD_BITS-1:0]         ry,
    output logic [pcross_pkg::ORIENT_BITS-1:0]   orient
);
    import pcross_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int VW = PW + 1;

    logic signed [DW-1:0] dqy_py;
    logic signed [DW-1:0] drx_qx;
    logic signed [DW-1:0] dqx_px;
    logic signed [DW-1:0] dry_qy;
    logic signed [PW-1:0] prod_a;
    logic signed [PW-1:0] prod_b;
    logic signed [VW-1:0] cross_v;

    assign dqy_py = DW'(qy) - DW'(py);
    assign drx_qx = DW'(rx) - DW'(qx);
    assign dqx_px = DW'(qx) - DW'(px);
    assign dry_qy = DW'(ry) - DW'(qy);

    assign prod_a = PW'(dqy_py) * PW'(drx_qx);
    assign prod_b = PW'(dqx_px) * PW'(dry_qy);

    assign cross_v = VW'(prod_a) - VW'(prod_b);

    always_comb
    begin
        if (cross_v == '0)
            orient = ORIENT_COLLINEAR;
        else if (cross_v[VW-1])
            orient = ORIENT_NEG;
        else
            orient = ORIENT_POS;
    end

endmodule

// ===== rtl/pcross_seg_test.sv =====
// segment against segment test: four orientations plus collinear overlap
// instantiates pcross_orient, uses pcross_pkg for orientation codes
module pcross_seg_test #(
    parameter int COORD_BITS = 16
) (
    input  logic signed [COORD_BITS-1:0] p1x,
    input  logic signed [COORD_BITS-1:0] p1y,
    input  logic signed [COORD_BITS-1:0] q1x,
    input  logic signed [COORD_BITS-1:0] q1y,
    input  logic signed [COORD_BITS-1:0] p2x,
    input  logic signed [COORD_BITS-1:0] p2y,
    input  logic signed [COORD_BITS-1:0] q2x,
    input  logic signed [COORD_BITS-1:0] q2y,
    output logic                         meet
);
    import pcross_pkg::*;

    logic [ORIENT_BITS-1:0] o1;
    logic [ORIENT_BITS-1:0] o2;
    logic [ORIENT_BITS-1:0] o3;
    logic [ORIENT_BITS-1:0] o4;
    logic                   on1;
    logic                   on2;
    logic                   on3;
    logic                   on4;

    // q inside the bounding box of p and r
    function automatic logic in_box(
        input logic signed [COORD_BITS-1:0] bpx,
        input logic signed [COORD_BITS-1:0] bpy,
        input logic signed [COORD_BITS-1:0] bqx,
        input logic signed [COORD_BITS-1:0] bqy,
        input logic signed [COORD_BITS-1:0] brx,
        input logic signed [COORD_BITS-1:0] bry
    );
        logic x_ok;
        logic y_ok;
        x_ok = (bpx < brx) ? (bqx >= bpx && bqx <= brx) : (bqx >= brx && bqx <= bpx);
        y_ok = (bpy < bry) ? (bqy >= bpy && bqy <= bry) : (bqy >= bry && bqy <= bpy);
        return x_ok && y_ok;
    endfunction

    pcross_orient #(.COORD_BITS(COORD_BITS)) u_o1 (
        .px(p1x), .py(p1y), .qx(q1x), .qy(q1y), .rx(p2x), .ry(p2y), .orient(o1)
    );
    pcross_orient #(.COORD_BITS(COORD_BITS)) u_o2 (
        .px(p1x), .py(p1y), .qx(q1x), .qy(q1y), .rx(q2x), .ry(q2y), .orient(o2)
    );
    pcross_orient #(.COORD_BITS(COORD_BITS)) u_o3 (
        .px(p2x), .py(p2y), .qx(q2x), .qy(q2y), .rx(p1x), .ry(p1y), .orient(o3)
    );
    pcross_orient #(.COORD_BITS(COORD_BITS)) u_o4 (
        .px(p2x), .py(p2y), .qx(q2x), .qy(q2y), .rx(q1x), .ry(q1y), .orient(o4)
    );

    // collinear endpoint lying on the other segment counts as a touch
    assign on1 = (o1 == ORIENT_COLLINEAR) && in_box(p1x, p1y, p2x, p2y, q1x, q1y);
    assign on2 = (o2 == ORIENT_COLLINEAR) && in_box(p1x, p1y, q2x, q2y, q1x, q1y);
    assign on3 = (o3 == ORIENT_COLLINEAR) && in_box(p2x, p2y, p1x, p1y, q2x, q2y);
    assign on4 = (o4 == ORIENT_COLLINEAR) && in_box(p2x, p2y, q1x, q1y, q2x, q2y);

    assign meet = ((o1 != o2) && (o3 != o4)) || on1 || on2 || on3 || on4;

endmodule
